/* sv/bqc_pkg.sv */
// Shared types, constants and the control program of the biquad cascade core.
`timescale 1ns / 1ps
`default_nettype none

package bqc_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 32;
  localparam int STATE_W   = 32;
  localparam int RAW_SUM_W = SAMPLE_W + 2;   // x + 2*x1 + x2 on raw samples
  localparam int SUM_W     = STATE_W + 2;    // x + 2*x1 + x2 in state format
  localparam int SPLIT_W   = 16;             // low slice of the sum for the scale product
  localparam int HI_W      = SUM_W - SPLIT_W;
  localparam int MUL_W     = 33;             // signed multiplier operand width
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 64;
  localparam int SCALE_FRAC_BITS = 40;
  localparam int CFG_IDX_W = 3;

  // Defaults of the top-level parameters.
  localparam int SECTIONS_DEF        = 2;
  localparam int COEF_FRAC_BITS_DEF  = 30;
  localparam int STATE_FRAC_BITS_DEF = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FB1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FB2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_FB1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_FB2   = 3'd5;

  // Reset values of the coefficient registers.
  localparam logic signed [COEF_W-1:0] RST_FIRST_SCALE  = 32'sd10324754;
  localparam logic signed [COEF_W-1:0] RST_FIRST_FB1    = -32'sd2142412620;
  localparam logic signed [COEF_W-1:0] RST_FIRST_FB2    = 32'sd1068711127;
  localparam logic signed [COEF_W-1:0] RST_SECOND_SCALE = 32'sd10290662;
  localparam logic signed [COEF_W-1:0] RST_SECOND_FB1   = -32'sd2135338377;
  localparam logic signed [COEF_W-1:0] RST_SECOND_FB2   = 32'sd1061636751;

  typedef struct packed {
    logic signed [COEF_W-1:0] first_scale;
    logic signed [COEF_W-1:0] first_fb1;
    logic signed [COEF_W-1:0] first_fb2;
    logic signed [COEF_W-1:0] second_scale;
    logic signed [COEF_W-1:0] second_fb1;
    logic signed [COEF_W-1:0] second_fb2;
  } coef_set_t;

  // Microcode fields.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SL,     // low sum slice * scale
    MUL_SH,     // high sum slice * scale
    MUL_A1,     // a1 * y[n-1]
    MUL_A2      // a2 * y[n-2]
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LO,     // acc = prod + half LSB of the scale format
    ACC_HI,     // acc = prod + (acc >>> 16)
    ACC_FF,     // acc = (acc >>> 24) - round(prod)
    ACC_FBW     // y = sat(acc - round(prod)), shift histories
  } acc_op_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_DONE_IF_ONE,   // end of program when only one section is built
    BR_DONE
  } br_t;

  typedef struct packed {
    logic    sec;
    logic    sum_en;
    mul_op_t mul;
    acc_op_t acc;
    br_t     br;
  } ucode_t;

  typedef struct packed {
    logic    en;
    logic    sec;
    logic    sum_en;
    mul_op_t mul;
    acc_op_t acc;
  } dp_ctl_t;

  localparam int PROG_LEN = 12;
  localparam int STEP_W   = $clog2(PROG_LEN);

  // Control program: six steps per section.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{sec: 1'b0, sum_en: 1'b0, mul: MUL_NONE, acc: ACC_NOP, br: BR_DONE};
    case (step)
      4'd0:  w = '{sec: 1'b0, sum_en: 1'b1, mul: MUL_NONE, acc: ACC_NOP, br: BR_NEXT};
      4'd1:  w = '{sec: 1'b0, sum_en: 1'b0, mul: MUL_SL,   acc: ACC_NOP, br: BR_NEXT};
      4'd2:  w = '{sec: 1'b0, sum_en: 1'b0, mul: MUL_SH,   acc: ACC_LO,  br: BR_NEXT};
      4'd3:  w = '{sec: 1'b0, sum_en: 1'b0, mul: MUL_A1,   acc: ACC_HI,  br: BR_NEXT};
      4'd4:  w = '{sec: 1'b0, sum_en: 1'b0, mul: MUL_A2,   acc: ACC_FF,  br: BR_NEXT};
      4'd5:  w = '{sec: 1'b0, sum_en: 1'b0, mul: MUL_NONE, acc: ACC_FBW,
                   br: BR_DONE_IF_ONE};
      4'd6:  w = '{sec: 1'b1, sum_en: 1'b1, mul: MUL_NONE, acc: ACC_NOP, br: BR_NEXT};
      4'd7:  w = '{sec: 1'b1, sum_en: 1'b0, mul: MUL_SL,   acc: ACC_NOP, br: BR_NEXT};
      4'd8:  w = '{sec: 1'b1, sum_en: 1'b0, mul: MUL_SH,   acc: ACC_LO,  br: BR_NEXT};
      4'd9:  w = '{sec: 1'b1, sum_en: 1'b0, mul: MUL_A1,   acc: ACC_HI,  br: BR_NEXT};
      4'd10: w = '{sec: 1'b1, sum_en: 1'b0, mul: MUL_A2,   acc: ACC_FF,  br: BR_NEXT};
      4'd11: w = '{sec: 1'b1, sum_en: 1'b0, mul: MUL_NONE, acc: ACC_FBW, br: BR_DONE};
      default: w = '{sec: 1'b0, sum_en: 1'b0, mul: MUL_NONE, acc: ACC_NOP, br: BR_DONE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* sv/bqc_seq.sv */
// Step counter and program ROM sequencer of the biquad cascade core.
`timescale 1ns / 1ps
`default_nettype none

module bqc_seq #(
  parameter int SECTIONS = bqc_pkg::SECTIONS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            out_free,
  output logic                 busy,
  output logic                 emit,
  output bqc_pkg::dp_ctl_t     ctl
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                       state_r;
  logic [bqc_pkg::STEP_W-1:0]   step_r;
  bqc_pkg::ucode_t              uc;
  logic                         last_step;
  logic                         stall;
  logic                         en;

  assign uc        = bqc_pkg::ucode(step_r);
  assign last_step = (uc.br == bqc_pkg::BR_DONE) ||
                     ((uc.br == bqc_pkg::BR_DONE_IF_ONE) && (SECTIONS == 1));
  // hold the last step until the output register can take the result
  assign stall     = last_step && !out_free;
  assign en        = (state_r == ST_RUN) && !stall;
  assign emit      = en && last_step;
  assign busy      = (state_r == ST_RUN);

  assign ctl = '{en: en, sec: uc.sec, sum_en: uc.sum_en, mul: uc.mul, acc: uc.acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (start) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (en) begin
            if (last_step) begin
              state_r <= ST_IDLE;
              step_r  <= '0;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
          step_r  <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/bqc_dp.sv */
// Datapath of the biquad cascade core: histories, tap sum, shared multiplier, accumulator.
`timescale 1ns / 1ps
`default_nettype none

module bqc_dp #(
  parameter int COEF_FRAC_BITS  = bqc_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_FRAC_BITS = bqc_pkg::STATE_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire bqc_pkg::dp_ctl_t                       ctl,
  input  wire bqc_pkg::coef_set_t                     coef,
  input  wire logic signed [bqc_pkg::SAMPLE_W-1:0]    sample,
  output logic signed [bqc_pkg::SAMPLE_W-1:0]         filtered
);

  localparam int SW = bqc_pkg::SAMPLE_W;
  localparam int YW = bqc_pkg::STATE_W;
  localparam int AW = bqc_pkg::ACC_W;

  localparam logic signed [AW-1:0] FB_HALF = AW'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] FF_HALF = AW'(64'sd1 <<< (bqc_pkg::SCALE_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] Y_MAX   = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] Y_MIN   = AW'(-64'sd2147483648);
  localparam logic signed [YW:0]   OUT_HALF = (YW+1)'(33'sd1 <<< (STATE_FRAC_BITS - 1));
  localparam logic signed [YW:0]   OUT_MAX  = (YW+1)'(33'sd32767);
  localparam logic signed [YW:0]   OUT_MIN  = (YW+1)'(-33'sd32768);

  // Histories: index 0 is n-1, index 1 is n-2.
  logic signed [SW-1:0] h1x_r [2];
  logic signed [YW-1:0] h1y_r [2];
  logic signed [YW-1:0] h2x_r [2];
  logic signed [YW-1:0] h2y_r [2];

  logic signed [bqc_pkg::SUM_W-1:0]     s_r;
  logic signed [bqc_pkg::PROD_W-1:0]    prod_r;
  logic signed [AW-1:0]                 acc_r;

  logic signed [bqc_pkg::RAW_SUM_W-1:0] raw_sum;
  logic signed [bqc_pkg::SUM_W-1:0]     sum1;
  logic signed [bqc_pkg::SUM_W-1:0]     sum2;
  logic signed [bqc_pkg::SUM_W-1:0]     s_nxt;

  logic signed [YW-1:0]                 scale_sel, a1_sel, a2_sel, y1_sel, y2_sel;
  logic signed [bqc_pkg::MUL_W-1:0]     mul_a, mul_b;
  logic signed [2*bqc_pkg::MUL_W-1:0]   mul_full;

  logic signed [AW-1:0] fb_rnd;
  logic signed [AW-1:0] fbw_v;
  logic signed [YW-1:0] y_sat;
  logic signed [YW:0]   y_rnd_sum;
  logic signed [YW:0]   y_rnd;

  // Tap sums: section one on raw samples then aligned to state format.
  assign raw_sum = bqc_pkg::RAW_SUM_W'(sample)
                 + (bqc_pkg::RAW_SUM_W'(h1x_r[0]) <<< 1)
                 + bqc_pkg::RAW_SUM_W'(h1x_r[1]);
  assign sum1    = bqc_pkg::SUM_W'(raw_sum) <<< STATE_FRAC_BITS;
  assign sum2    = bqc_pkg::SUM_W'(h1y_r[0])
                 + (bqc_pkg::SUM_W'(h2x_r[0]) <<< 1)
                 + bqc_pkg::SUM_W'(h2x_r[1]);
  assign s_nxt   = ctl.sec ? sum2 : sum1;

  assign scale_sel = ctl.sec ? coef.second_scale : coef.first_scale;
  assign a1_sel    = ctl.sec ? coef.second_fb1   : coef.first_fb1;
  assign a2_sel    = ctl.sec ? coef.second_fb2   : coef.first_fb2;
  assign y1_sel    = ctl.sec ? h2y_r[0] : h1y_r[0];
  assign y2_sel    = ctl.sec ? h2y_r[1] : h1y_r[1];

  always_comb begin
    case (ctl.mul)
      bqc_pkg::MUL_SL: begin
        mul_a = $signed({(bqc_pkg::MUL_W - bqc_pkg::SPLIT_W)'(0),
                         s_r[bqc_pkg::SPLIT_W-1:0]});
        mul_b = bqc_pkg::MUL_W'(scale_sel);
      end
      bqc_pkg::MUL_SH: begin
        mul_a = bqc_pkg::MUL_W'($signed(s_r[bqc_pkg::SUM_W-1:bqc_pkg::SPLIT_W]));
        mul_b = bqc_pkg::MUL_W'(scale_sel);
      end
      bqc_pkg::MUL_A1: begin
        mul_a = bqc_pkg::MUL_W'(a1_sel);
        mul_b = bqc_pkg::MUL_W'(y1_sel);
      end
      bqc_pkg::MUL_A2: begin
        mul_a = bqc_pkg::MUL_W'(a2_sel);
        mul_b = bqc_pkg::MUL_W'(y2_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // feedback product rounded half up to state format
  assign fb_rnd = (prod_r + FB_HALF) >>> COEF_FRAC_BITS;
  assign fbw_v  = acc_r - fb_rnd;

  always_comb begin
    if (fbw_v > Y_MAX) begin
      y_sat = YW'(Y_MAX);
    end else if (fbw_v < Y_MIN) begin
      y_sat = YW'(Y_MIN);
    end else begin
      y_sat = fbw_v[YW-1:0];
    end
  end

  assign y_rnd_sum = (YW+1)'(y_sat) + OUT_HALF;
  assign y_rnd     = y_rnd_sum >>> STATE_FRAC_BITS;

  always_comb begin
    if (y_rnd > OUT_MAX) begin
      filtered = SW'(OUT_MAX);
    end else if (y_rnd < OUT_MIN) begin
      filtered = SW'(OUT_MIN);
    end else begin
      filtered = y_rnd[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.sum_en) begin
      s_r <= s_nxt;
    end
    if (ctl.en && (ctl.mul != bqc_pkg::MUL_NONE)) begin
      prod_r <= $signed(mul_full[bqc_pkg::PROD_W-1:0]);
    end
    if (ctl.en) begin
      case (ctl.acc)
        bqc_pkg::ACC_LO: acc_r <= prod_r + FF_HALF;
        bqc_pkg::ACC_HI: acc_r <= prod_r + (acc_r >>> bqc_pkg::SPLIT_W);
        bqc_pkg::ACC_FF: acc_r <= (acc_r >>> (bqc_pkg::SCALE_FRAC_BITS - bqc_pkg::SPLIT_W))
                                  - fb_rnd;
        default: acc_r <= acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1x_r <= '{default: '0};
      h1y_r <= '{default: '0};
      h2x_r <= '{default: '0};
      h2y_r <= '{default: '0};
    end else if (ctl.en && (ctl.acc == bqc_pkg::ACC_FBW)) begin
      if (ctl.sec) begin
        h2x_r[1] <= h2x_r[0];
        h2x_r[0] <= h1y_r[0];
        h2y_r[1] <= h2y_r[0];
        h2y_r[0] <= y_sat;
      end else begin
        h1x_r[1] <= h1x_r[0];
        h1x_r[0] <= sample;
        h1y_r[1] <= h1y_r[0];
        h1y_r[0] <= y_sat;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/biquad_cascade_lowpass_df1_core.sv */
// Top level of the two-section direct form I Butterworth low-pass biquad cascade.
`timescale 1ns / 1ps
`default_nettype none

// Cascaded low-pass biquad core. Each request on the in_ stream carries one
// signed 16-bit sample; the core runs it through section one and then section
// two (y = scale*(x + 2*x1 + x2) - a1*y1 - a2*y2, Q16.16 state, a1/a2 in
// Q2.30 with COEF_FRAC_BITS fraction bits, scale over 2^40) and returns one
// request on the out_ stream with the rounded, saturated 16-bit result.
// Timing: one sample is worked at a time. After the input request is taken,
// a 12-step microcode program (6 steps per section) runs on one shared
// 33x33 multiplier and a 64-bit accumulator; the result lands in the output
// register at the end of the last step and in_tready returns in the same
// cycle. A result still waiting in the output register does not stop the
// next sample from being taken; only the final step waits for it.
// Coefficients are written over the cfg_ port (index 0..5 in the order
// first_scale, first_feedback_one, first_feedback_two, second_scale,
// second_feedback_one, second_feedback_two; other indexes are dropped) and
// must only be changed while the core is idle. Reset restores the default
// coefficients and clears all filter history.

module biquad_cascade_lowpass_df1_core #(
  parameter int SECTIONS        = bqc_pkg::SECTIONS_DEF,
  parameter int COEF_FRAC_BITS  = bqc_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_FRAC_BITS = bqc_pkg::STATE_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input sample stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bqc_pkg::SAMPLE_W-1:0]      in_tdata,   // [15:0] sample
  // filtered output stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bqc_pkg::SAMPLE_W-1:0]           out_tdata,  // [15:0] filtered
  // coefficient write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bqc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bqc_pkg::COEF_W-1:0]        cfg_data
);

  bqc_pkg::coef_set_t                    coef_r;
  logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_r;
  logic                                  out_valid_r;
  logic [bqc_pkg::SAMPLE_W-1:0]          out_data_r;

  bqc_pkg::dp_ctl_t                      ctl;
  logic                                  busy;
  logic                                  emit;
  logic                                  out_free;
  logic                                  in_acc;
  logic signed [bqc_pkg::SAMPLE_W-1:0]   filtered;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !busy;
  assign in_acc     = in_tvalid && in_tready;
  // the output register frees up in the same cycle its request is taken
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.first_scale  <= bqc_pkg::RST_FIRST_SCALE;
      coef_r.first_fb1    <= bqc_pkg::RST_FIRST_FB1;
      coef_r.first_fb2    <= bqc_pkg::RST_FIRST_FB2;
      coef_r.second_scale <= bqc_pkg::RST_SECOND_SCALE;
      coef_r.second_fb1   <= bqc_pkg::RST_SECOND_FB1;
      coef_r.second_fb2   <= bqc_pkg::RST_SECOND_FB2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bqc_pkg::REG_FIRST_SCALE:  coef_r.first_scale  <= $signed(cfg_data);
        bqc_pkg::REG_FIRST_FB1:    coef_r.first_fb1    <= $signed(cfg_data);
        bqc_pkg::REG_FIRST_FB2:    coef_r.first_fb2    <= $signed(cfg_data);
        bqc_pkg::REG_SECOND_SCALE: coef_r.second_scale <= $signed(cfg_data);
        bqc_pkg::REG_SECOND_FB1:   coef_r.second_fb1   <= $signed(cfg_data);
        bqc_pkg::REG_SECOND_FB2:   coef_r.second_fb2   <= $signed(cfg_data);
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // Sample holding register, loaded on the input request.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= $signed(in_tdata);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= filtered;
    end
  end

  bqc_seq #(
    .SECTIONS (SECTIONS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .out_free (out_free),
    .busy     (busy),
    .emit     (emit),
    .ctl      (ctl)
  );

  bqc_dp #(
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .coef     (coef_r),
    .sample   (sample_r),
    .filtered (filtered)
  );

endmodule

`default_nettype wire

/* sv/bqc_checker.sv */
// Port-level assertions for the biquad cascade core and their bind.
`timescale 1ns / 1ps
`default_nettype none

module bqc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [bqc_pkg::SAMPLE_W-1:0]  out_tdata
);

  // a taken sample keeps the core busy; in_tready does not return early
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready)
    else $error("in_tready back too early after a sample request");

  // no result shows up right behind a newly taken sample
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid) ##1 !$rose(out_tvalid))
    else $error("result appeared too soon after a sample request");

  // a new result coincides with the core turning idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result posted while the core still reports busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output request changed");

endmodule

bind biquad_cascade_lowpass_df1_core bqc_checker u_bqc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* dv/biquad_cascade_lowpass_df1_core_tb.sv */
// Self-checking testbench for the two-section direct form I low-pass biquad cascade core.
`timescale 1ns / 1ps

// Stimulus plan:
//   - reset, then a short directed table (zero input after reset, sample
//     extremes, zero-gain coefficients, writes to unused indexes, extreme
//     coefficients that drive both sections into saturation)
//   - random phases: each one reprograms all six coefficients while the core
//     is idle, then streams runs of samples (steps, ramps, noise, corner
//     values, small values) with random gaps on both streams
//   - the output side holds off for long stretches at two points so the core
//     fills up and stalls its input
// Every accepted input request is run through a local fixed-point model of
// the cascade; results are compared in order against the queue of expected
// filtered samples.

module biquad_cascade_lowpass_df1_core_tb;
  import bqc_pkg::*;

  localparam int NSEC         = SECTIONS_DEF;
  localparam int CFB          = COEF_FRAC_BITS_DEF;
  localparam int SFB          = STATE_FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 40;     // margin for the core to finish its program
  localparam int LONG_HOLD    = 400;    // output back-pressure, in cycles
  localparam int FIRST_HOLD_AT  = 40;
  localparam int SECOND_HOLD_AT = 1000;
  localparam int MAX_REPORTS  = 10;

  // Indexes the core must ignore.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Rounding offsets and clamp bounds, all at a width wide enough for exact math.
  localparam logic signed [127:0] HALF_SCALE = 128'sd1 <<< (SCALE_FRAC_BITS - 1);
  localparam logic signed [127:0] HALF_COEF  = 128'sd1 <<< (CFB - 1);
  localparam logic signed [127:0] HALF_STATE = 128'sd1 <<< (SFB - 1);
  localparam logic signed [127:0] STATE_MAX  = 128'sd2147483647;
  localparam logic signed [127:0] STATE_MIN  = -128'sd2147483648;
  localparam logic signed [127:0] SAMPLE_MAX = 128'sd32767;
  localparam logic signed [127:0] SAMPLE_MIN = -128'sd32768;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [2:0] {RUN_HOLD, RUN_RAMP, RUN_NOISE, RUN_CORNER, RUN_SMALL} run_shape_t;
  typedef enum logic [1:0] {COEF_NOMINAL, COEF_NEAR, COEF_WILD, COEF_CORNER} coef_style_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    val;
    logic [SAMPLE_W-1:0]  smp;
    bit                   typed;   // expected result given in the row
    logic [SAMPLE_W-1:0]  want;
  } stim_row_t;

  typedef struct {
    logic [SAMPLE_W-1:0] filtered;
    int                  seq;
  } filt_exp_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [SAMPLE_W-1:0]  in_tdata   = '0;     // [15:0] sample
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SAMPLE_W-1:0]  out_tdata;           // [15:0] filtered
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [COEF_W-1:0]    cfg_data   = '0;

  biquad_cascade_lowpass_df1_core #(
    .SECTIONS       (NSEC),
    .COEF_FRAC_BITS (CFB),
    .STATE_FRAC_BITS(SFB)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cascade model: coefficient copy and per-section delay lines
  // ---------------------------------------------------------------------------
  coef_set_t                  coefs;
  logic signed [SAMPLE_W-1:0] sec1_x_hist [2];   // raw samples x[n-1], x[n-2]
  logic signed [STATE_W-1:0]  sec1_y_hist [2];
  logic signed [STATE_W-1:0]  sec2_x_hist [2];
  logic signed [STATE_W-1:0]  sec2_y_hist [2];

  filt_exp_t expected_filtered [$];
  stim_row_t stim_rows [$];
  int        accepted_cnt = 0;
  int        result_cnt   = 0;
  int        err_cnt      = 0;
  bit        sender_quiet = 1'b0;
  bit        busy_since_idle = 1'b0;

  // One section: tap_sum is x + 2*x1 + x2 already in state format.
  // Gain product rounded half up at 2^40, each feedback product rounded
  // half up separately, sum saturated to 32 bits.
  function automatic logic signed [STATE_W-1:0] biquad_section(
      input logic signed [127:0]       tap_sum,
      input logic signed [COEF_W-1:0]  scale,
      input logic signed [COEF_W-1:0]  fb1, fb2,
      input logic signed [STATE_W-1:0] y1, y2);
    logic signed [127:0] sc, a1, a2, p1, p2, acc;
    sc = 128'(scale);
    a1 = 128'(fb1);
    a2 = 128'(fb2);
    p1 = 128'(y1);
    p2 = 128'(y2);
    acc = ((tap_sum * sc + HALF_SCALE) >>> SCALE_FRAC_BITS)
        - ((a1 * p1 + HALF_COEF) >>> CFB)
        - ((a2 * p2 + HALF_COEF) >>> CFB);
    if (acc > STATE_MAX) acc = STATE_MAX;
    else if (acc < STATE_MIN) acc = STATE_MIN;
    return acc[STATE_W-1:0];
  endfunction

  // Runs one sample through the cascade, advances the delay lines and
  // returns the rounded, saturated 16-bit output.
  function automatic logic [SAMPLE_W-1:0] lowpass_predict(
      input logic signed [SAMPLE_W-1:0] smp);
    logic signed [127:0]       x0, x1, x2, sum, r;
    logic signed [STATE_W-1:0] y_first, y_last;
    x0  = 128'(smp);
    x1  = 128'(sec1_x_hist[0]);
    x2  = 128'(sec1_x_hist[1]);
    sum = (x0 + 2 * x1 + x2) <<< SFB;
    y_first = biquad_section(sum, coefs.first_scale, coefs.first_fb1, coefs.first_fb2,
                             sec1_y_hist[0], sec1_y_hist[1]);
    sec1_x_hist[1] = sec1_x_hist[0];
    sec1_x_hist[0] = smp;
    sec1_y_hist[1] = sec1_y_hist[0];
    sec1_y_hist[0] = y_first;
    y_last = y_first;
    if (NSEC >= 2) begin
      x0  = 128'(y_first);
      x1  = 128'(sec2_x_hist[0]);
      x2  = 128'(sec2_x_hist[1]);
      sum = x0 + 2 * x1 + x2;
      y_last = biquad_section(sum, coefs.second_scale, coefs.second_fb1,
                              coefs.second_fb2, sec2_y_hist[0], sec2_y_hist[1]);
      sec2_x_hist[1] = sec2_x_hist[0];
      sec2_x_hist[0] = y_first;
      sec2_y_hist[1] = sec2_y_hist[0];
      sec2_y_hist[0] = y_last;
    end
    r = 128'(y_last);
    r = (r + HALF_STATE) >>> SFB;
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    else if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    return r[SAMPLE_W-1:0];
  endfunction

  // Mostly back-to-back, some short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void row_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                                     input logic [SAMPLE_W-1:0] want);
    stim_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = '0;
    row.val   = '0;
    row.smp   = smp;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  function automatic void row_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COEF_W-1:0] val);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.val   = val;
    row.smp   = '0;
    row.typed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge, returns at a falling edge; valid
  // stays high between back-to-back requests.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                             input logic [SAMPLE_W-1:0] typed_val);
    int        gap;
    filt_exp_t entry;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = smp;
    do @(posedge clk); while (!in_tready);
    // model always advances so its state tracks the core
    entry.filtered = lowpass_predict(smp);
    if (typed) entry.filtered = typed_val;
    entry.seq = accepted_cnt;
    expected_filtered.push_back(entry);
    accepted_cnt++;
    busy_since_idle = 1'b1;
    @(negedge clk);
  endtask

  // Coefficients change only with the core idle: all results in, plus a
  // margin for the program to finish.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    in_tvalid = 1'b0;
    if (busy_since_idle) begin
      while (expected_filtered.size() != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
      busy_since_idle = 1'b0;
    end
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIRST_SCALE:  coefs.first_scale  = val;
      REG_FIRST_FB1:    coefs.first_fb1    = val;
      REG_FIRST_FB2:    coefs.first_fb2    = val;
      REG_SECOND_SCALE: coefs.second_scale = val;
      REG_SECOND_FB1:   coefs.second_fb1   = val;
      REG_SECOND_FB2:   coefs.second_fb2   = val;
      default: ;   // unused index, dropped by the core
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(input coef_style_t style,
                                                  input logic [COEF_W-1:0] nominal,
                                                  input int span);
    int off;
    case (style)
      COEF_NOMINAL: return nominal;
      COEF_NEAR: begin
        off = int'($urandom_range(0, 2 * span)) - span;
        return nominal + off;
      end
      COEF_WILD: return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random ready pattern with long quiet stretches and two
  // long hold-offs that back the core up into its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int burst, gap, holds_done;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      if ((holds_done == 0 && result_cnt >= FIRST_HOLD_AT) ||
          (holds_done == 1 && result_cnt >= SECOND_HOLD_AT)) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end
      burst = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
      out_tready = 1'b1;
      repeat (burst) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Result checker: in-order compare against the oldest expectation.
  always @(posedge clk) begin
    filt_exp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      result_cnt++;
      if (expected_filtered.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("ERROR: unexpected result 0x%04h at %0t", out_tdata, $realtime);
      end else begin
        want = expected_filtered.pop_front();
        if (out_tdata !== want.filtered) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("ERROR: sample #%0d filtered expected %0d (0x%04h), got %0d (0x%04h)",
                     want.seq, $signed(want.filtered), want.filtered,
                     $signed(out_tdata), out_tdata);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_IDX_W-1:0] reg_ids [6];
    logic [COEF_W-1:0]    nominal [6];
    int                   spans [6];
    logic [SAMPLE_W-1:0]  corner_samples [5];
    logic [SAMPLE_W-1:0]  smp;
    coef_style_t          style;
    run_shape_t           shape;
    int n_left, phase, phase_len, run_len, level, step, pick;

    reg_ids[0] = REG_FIRST_SCALE;   nominal[0] = RST_FIRST_SCALE;   spans[0] = 1 << 22;
    reg_ids[1] = REG_FIRST_FB1;     nominal[1] = RST_FIRST_FB1;     spans[1] = 1 << 12;
    reg_ids[2] = REG_FIRST_FB2;     nominal[2] = RST_FIRST_FB2;     spans[2] = 1 << 12;
    reg_ids[3] = REG_SECOND_SCALE;  nominal[3] = RST_SECOND_SCALE;  spans[3] = 1 << 22;
    reg_ids[4] = REG_SECOND_FB1;    nominal[4] = RST_SECOND_FB1;    spans[4] = 1 << 12;
    reg_ids[5] = REG_SECOND_FB2;    nominal[5] = RST_SECOND_FB2;    spans[5] = 1 << 12;
    corner_samples[0] = 16'h8000;
    corner_samples[1] = 16'h7FFF;
    corner_samples[2] = 16'h0000;
    corner_samples[3] = 16'hFFFF;
    corner_samples[4] = 16'h0001;

    // model reset state mirrors the core's
    coefs.first_scale  = RST_FIRST_SCALE;
    coefs.first_fb1    = RST_FIRST_FB1;
    coefs.first_fb2    = RST_FIRST_FB2;
    coefs.second_scale = RST_SECOND_SCALE;
    coefs.second_fb1   = RST_SECOND_FB1;
    coefs.second_fb2   = RST_SECOND_FB2;
    for (int k = 0; k < 2; k++) begin
      sec1_x_hist[k] = '0;
      sec1_y_hist[k] = '0;
      sec2_x_hist[k] = '0;
      sec2_y_hist[k] = '0;
    end

    // Directed table. Typed results only where obvious: silence after reset
    // and anything through zero gain with zero feedback.
    row_sample(16'h0000, 1'b1, 16'h0000);
    row_sample(16'h0000, 1'b1, 16'h0000);
    row_sample(16'h7FFF, 1'b0, '0);
    row_sample(16'h8000, 1'b0, '0);
    row_sample(16'h0001, 1'b0, '0);
    row_sample(16'hFFFF, 1'b0, '0);
    row_sample(16'h5555, 1'b0, '0);
    row_sample(16'hAAAA, 1'b0, '0);
    // zero gain, no feedback: output is zero whatever the history
    row_write(REG_FIRST_SCALE,  32'h0000_0000);
    row_write(REG_FIRST_FB1,    32'h0000_0000);
    row_write(REG_FIRST_FB2,    32'h0000_0000);
    row_write(REG_SECOND_SCALE, 32'h0000_0000);
    row_write(REG_SECOND_FB1,   32'h0000_0000);
    row_write(REG_SECOND_FB2,   32'h0000_0000);
    row_sample(16'h7FFF, 1'b1, 16'h0000);
    row_sample(16'h8000, 1'b1, 16'h0000);
    // unused indexes must leave the coefficients alone
    row_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    row_write(REG_SPARE_HI, 32'h7FFF_FFFF);
    row_sample(16'h7FFF, 1'b1, 16'h0000);
    // maximum gain, a1 = -2, a2 = ~+2: unstable, both sections saturate
    row_write(REG_FIRST_SCALE,  32'h7FFF_FFFF);
    row_write(REG_FIRST_FB1,    32'h8000_0000);
    row_write(REG_FIRST_FB2,    32'h7FFF_FFFF);
    row_write(REG_SECOND_SCALE, 32'h7FFF_FFFF);
    row_write(REG_SECOND_FB1,   32'h8000_0000);
    row_write(REG_SECOND_FB2,   32'h7FFF_FFFF);
    repeat (6) row_sample(16'h7FFF, 1'b0, '0);
    repeat (4) row_sample(16'h8000, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE)
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      else
        send_sample(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].want);
    end

    // Random phases. First phase restores the default filter; later ones
    // are mostly perturbed low-pass sets, the rest wild or corner values.
    n_left = RANDOM_ITEMS;
    phase  = 0;
    while (n_left > 0) begin
      pick = $urandom_range(0, 3);
      for (int k = 0; k < 6; k++) begin
        if (phase == 0)     style = COEF_NOMINAL;
        else if (pick <= 1) style = COEF_NEAR;
        else if (pick == 2) begin
          case ($urandom_range(0, 3))
            0:       style = COEF_NOMINAL;
            1:       style = COEF_NEAR;
            2:       style = COEF_WILD;
            default: style = COEF_CORNER;
          endcase
        end else
          style = ($urandom_range(0, 1) == 0) ? COEF_WILD : COEF_CORNER;
        write_reg(reg_ids[k], pick_coef(style, nominal[k], spans[k]));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());

      phase_len = $urandom_range(150, 260);
      if (phase_len > n_left) phase_len = n_left;
      n_left -= phase_len;
      phase++;

      // runs of samples: steps and ramps let the filter settle, noise and
      // corners exercise every bit and the saturation paths
      while (phase_len > 0) begin
        run_len = $urandom_range(8, 80);
        if (run_len > phase_len) run_len = phase_len;
        phase_len -= run_len;
        pick = $urandom_range(0, 9);
        if (pick <= 3)      shape = RUN_HOLD;
        else if (pick <= 5) shape = RUN_RAMP;
        else if (pick <= 7) shape = RUN_NOISE;
        else if (pick == 8) shape = RUN_CORNER;
        else                shape = RUN_SMALL;
        sender_quiet = ($urandom_range(0, 4) == 0);
        level = int'($urandom_range(0, 65535)) - 32768;
        step  = int'($urandom_range(0, 2000)) - 1000;
        repeat (run_len) begin
          case (shape)
            RUN_HOLD: smp = level[SAMPLE_W-1:0];
            RUN_RAMP: begin
              level += step;
              if (level > 32767) begin
                level = 32767;
                step  = -step;
              end else if (level < -32768) begin
                level = -32768;
                step  = -step;
              end
              smp = level[SAMPLE_W-1:0];
            end
            RUN_NOISE:  smp = SAMPLE_W'($urandom());
            RUN_CORNER: smp = corner_samples[$urandom_range(0, 4)];
            default: begin
              level = int'($urandom_range(0, 63)) - 32;
              smp   = level[SAMPLE_W-1:0];
            end
          endcase
          send_sample(smp, 1'b0, '0);
        end
      end
    end

    // drain: every expectation met, then let the core settle
    in_tvalid    = 1'b0;
    sender_quiet = 1'b0;
    while (expected_filtered.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_cnt == 0 && expected_filtered.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
